// ----- sv/tpr_pkg.sv -----
// Shared types and constants for the timer prescaler / reload search unit.
// Request and result structs, status codes, divider sizing.
// No dependencies.
package tpr_pkg;

	localparam int NUM_W   = 32;
	localparam int STEP_W  = 5;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

	localparam logic [1:0] ST_EXACT      = 2'd0;
	localparam logic [1:0] ST_MISMATCH   = 2'd1;
	localparam logic [1:0] ST_INACCURATE = 2'd2;

	localparam logic [30:0] CLK_HZ_RESET = 31'd72000000;

	typedef struct packed {
		logic        request_is_frequency;
		logic [30:0] request_value;
	} in_t;

	typedef struct packed {
		logic [15:0] prescaler_value;
		logic [15:0] reload_value;
		logic [30:0] achieved_freq;
		logic [1:0]  status;
	} out_t;

endpackage

// ----- sv/tpr_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Uses tpr_pkg for dividend width and step count.
module tpr_div import tpr_pkg::*; #(
	parameter int DEN_W = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    rem_nx;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_LAST) && !start;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- sv/timer_prescaler_reload_search_unit.sv -----
// Timer prescaler / auto-reload search: sequencer, search registers and result register.
// Depends on tpr_pkg and tpr_div.
//
//  channel | signals                        | moves
//  in      | in_valid, in_ready, in_data    | one request (frequency or count)
//  out     | out_valid, out_ready, out_data | prescaler, reload, frequency, status
//  cfg     | cfg_valid, cfg_ready, cfg_data | timer clock in hertz, always ready
//
// Every division runs on one shared radix-2 divider. A nonzero frequency request first
// needs one division to get a count, and the search needs one per divisor trial.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next request can be taken before it is delivered.
// Reset restores the clock register to 72 MHz and clears all handshake state.
module timer_prescaler_reload_search_unit import tpr_pkg::*; #(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data
);

	localparam int CB    = COUNTER_BITS;
	localparam int PW    = 2 * CB + 2;
	localparam int DEN_W = (PW > NUM_W) ? PW : NUM_W;
	localparam logic [63:0]   LIM_W = (64'd1 << CB) - 64'd1;
	localparam logic [CB-1:0] LIM_C = '1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FDIV  = 8'b0000_0010,
		S_CLASS = 8'b0000_0100,
		S_SDIV  = 8'b0000_1000,
		S_PROD  = 8'b0001_0000,
		S_AST   = 8'b0010_0000,
		S_ADIV  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [30:0]       clk_hz_q;
	logic              out_valid_q;
	out_t              out_q;
	logic [30:0]       cnt_q;
	logic [CB-1:0]     ratio_q;
	logic [CB-1:0]     best_err_q;
	logic [CB-1:0]     best_ratio_q;
	logic [CB-1:0]     best_quo_q;
	logic [CB-1:0]     psc_q;
	logic [CB-1:0]     arr_q;
	logic [1:0]        st_q;
	logic [PW-1:0]     prod_q;
	logic [30:0]       ach_q;

	logic              div_start;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [NUM_W-1:0]  div_quo;
	logic [DEN_W-1:0]  div_rem;

	logic [30:0]       cnt_hi;
	logic              too_big;
	logic              cnt_small;
	logic [CB-1:0]     ratio_first;
	logic [CB-1:0]     rem_cb;
	logic [CB-1:0]     quo_cb;
	logic              better;
	logic              exact;
	logic              search_end;
	logic [CB-1:0]     sel_ratio;
	logic [CB-1:0]     sel_quo;
	logic [CB-1:0]     psc_n;
	logic [CB-1:0]     arr_n;
	logic [NUM_W-1:0]  fround;
	logic              out_load;
	logic              in_acc;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cnt_hi      = cnt_q >> CB;
	assign too_big     = {33'd0, cnt_hi} >= LIM_W;
	assign cnt_small   = {33'd0, cnt_q} <= LIM_W;
	assign ratio_first = CB'(cnt_hi + 31'd1);
	assign rem_cb      = CB'(div_rem);
	assign quo_cb      = CB'(div_quo);
	assign better      = rem_cb < best_err_q;
	assign exact       = (div_rem == '0);
	assign search_end  = exact || (ratio_q == LIM_C);
	assign sel_ratio   = better ? ratio_q : best_ratio_q;
	assign sel_quo     = better ? quo_cb : best_quo_q;
	assign psc_n       = (sel_ratio > sel_quo) ? (sel_quo - CB'(1)) : (sel_ratio - CB'(1));
	assign arr_n       = (sel_ratio > sel_quo) ? (sel_ratio - CB'(1)) : (sel_quo - CB'(1));
	assign fround      = div_quo + NUM_W'(1);
	assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(cnt_q);
		div_den   = DEN_W'(ratio_q) + DEN_W'(1);
		case (state_q)
			S_IDLE: begin
				div_num = {clk_hz_q, 1'b0};
				div_den = DEN_W'(in_data.request_value);
				div_start = in_acc && in_data.request_is_frequency &&
					(in_data.request_value != '0);
			end
			S_CLASS: begin
				div_den = DEN_W'(ratio_first);
				div_start = (cnt_q != '0) && !cnt_small && !too_big;
			end
			S_SDIV: begin
				div_start = div_done && !search_end;
			end
			S_AST: begin
				div_num = NUM_W'(clk_hz_q);
				div_den = DEN_W'(prod_q);
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	tpr_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clk_hz_q    <= CLK_HZ_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				clk_hz_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (div_start) begin
							state_q <= S_FDIV;
						end else begin
							state_q <= S_CLASS;
						end
					end
				end
				S_FDIV: begin
					if (div_done) begin
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					if (div_start) begin
						state_q <= S_SDIV;
					end else begin
						state_q <= S_PROD;
					end
				end
				S_SDIV: begin
					if (div_done && search_end) begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					state_q <= S_AST;
				end
				S_AST: begin
					state_q <= S_ADIV;
				end
				S_ADIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_data.request_is_frequency) begin
						cnt_q <= '0;
					end else begin
						cnt_q <= in_data.request_value;
					end
				end
			end
			S_FDIV: begin
				if (div_done) begin
					cnt_q <= fround[NUM_W-1:1];
				end
			end
			S_CLASS: begin
				ratio_q    <= ratio_first;
				best_err_q <= '1;
				if (cnt_q == '0) begin
					psc_q <= '0;
					arr_q <= CB'(1);
					st_q  <= ST_MISMATCH;
				end else if (cnt_small) begin
					psc_q <= '0;
					arr_q <= CB'(cnt_q - 31'd1);
					st_q  <= ST_EXACT;
				end else begin
					psc_q <= LIM_C;
					arr_q <= LIM_C;
					st_q  <= ST_INACCURATE;
				end
			end
			S_SDIV: begin
				if (div_done) begin
					if (better) begin
						best_err_q   <= rem_cb;
						best_ratio_q <= ratio_q;
						best_quo_q   <= quo_cb;
					end
					if (search_end) begin
						psc_q <= psc_n;
						arr_q <= arr_n;
						st_q  <= exact ? ST_EXACT : ST_INACCURATE;
					end else begin
						ratio_q <= ratio_q + CB'(1);
					end
				end
			end
			S_PROD: begin
				prod_q <= PW'({1'b0, psc_q} + (CB + 1)'(1)) *
					PW'({1'b0, arr_q} + (CB + 1)'(1));
			end
			S_ADIV: begin
				if (div_done) begin
					ach_q <= div_quo[30:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.prescaler_value <= 16'(psc_q);
			out_q.reload_value    <= 16'(arr_q);
			out_q.achieved_freq   <= ach_q;
			out_q.status          <= st_q;
		end
	end

endmodule

// ----- sv/tpr_chk.sv -----
// Port-level checks for the timer prescaler / reload search unit, bound to the top level.
// Depends on tpr_pkg.
module tpr_chk import tpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_valid,
	input logic cfg_ready
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request dropped or changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new request taken while search in progress");

	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_MISMATCH) |->
			(out_data.prescaler_value == 16'd0) && (out_data.reload_value == 16'd1))
		else $error("mismatch result without default divider pair");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("clock register write stalled");

endmodule

bind timer_prescaler_reload_search_unit tpr_chk u_tpr_chk (.*);
